// ===== hdl/pid_pkg.sv =====
// Package: shared constants and types for the PID control step block.
`timescale 1ns / 1ps
`default_nettype none
package pid_pkg;
  localparam int unsigned DerivAlphaDefault = 32768;
  localparam int unsigned OutAlphaDefault   = 32768;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] RegMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainP  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainI  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainD  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutLim = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIntLim = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDead   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBands  = 3'd7;

  typedef struct packed {
    logic signed [31:0] measured;
    logic signed [31:0] target;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               in_dead_zone;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/pid_if.sv =====
// Interfaces: valid/ready item channels of the PID control step block.
`timescale 1ns / 1ps
`default_nettype none
interface pid_in_if;
  logic valid;
  logic ready;
  pid_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pid_out_if;
  logic valid;
  logic ready;
  pid_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pid_control_step.sv =====
// Top level: PID control step, sequenced over one shared multiplier and divider.
// Usage:
//  in_ch  carries one item (measured, target) per control tick, signed Q16.16.
//  out_ch returns one item (drive, in_dead_zone) for every input item.
//  cfg_we_i/cfg_idx_i/cfg_data_i write the mode and gain registers while idle.
// Sequencing:
//  An item runs through a sequencer that uses one 33x33 multiplier and one
//  radix-2 divider (64 steps, only when integral separation scales the step).
//  Inside the dead zone an item goes from S_ERR straight to S_OUT; otherwise
//  it passes S_ERR, S_P, S_I, S_D, S_AW, S_SUM and S_OUT, plus S_DF1/S_DF2
//  and S_OF1/S_OF2 for the enabled filters and S_SEP/S_DIV when separation
//  scales the integral step. One item is in flight at a time; in_ch.ready
//  is high only while the sequencer is idle.
// Reset:
//  Registers return to their defaults (limits all ones, rest zero) and the
//  controller history is cleared.
// Stall:
//  A result waits in the output register until out_ch.ready; the sequencer
//  may take one more item and holds it in its last step until the register
//  is free, then in_ch.ready stays low.
`timescale 1ns / 1ps
`default_nettype none
module pid_control_step #(
  parameter int unsigned DERIV_FILTER_ALPHA  = pid_pkg::DerivAlphaDefault,
  parameter int unsigned OUTPUT_FILTER_ALPHA = pid_pkg::OutAlphaDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  pid_in_if.sink                       in_ch,
  pid_out_if.source                    out_ch,
  input  wire                          cfg_we_i,
  input  wire [pid_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [pid_pkg::CfgDataW-1:0]  cfg_data_i
);
  localparam logic signed [32:0] DA  = 33'(DERIV_FILTER_ALPHA);
  localparam logic signed [32:0] DAN = 33'(65536 - DERIV_FILTER_ALPHA);
  localparam logic signed [32:0] OA  = 33'(OUTPUT_FILTER_ALPHA);
  localparam logic signed [32:0] OAN = 33'(65536 - OUTPUT_FILTER_ALPHA);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_P, S_I, S_SEP, S_DIV, S_D, S_DF1, S_DF2, S_AW,
    S_SUM, S_OF1, S_OF2, S_OUT
  } state_e;

  state_e state_q;
  logic [7:0]  mode_q;
  logic signed [31:0] gp_q, gi_q, gd_q;
  logic [30:0] olim_q, ilim_q, dz_q;
  logic [63:0] bands_q;
  logic signed [31:0] pe_q, pe2_q, pm_q, pm2_q, isum_q, pd_q, pdrv_q;
  logic signed [31:0] meas_q, err_q, p_q, i_q, d_q, drv_q;
  logic signed [65:0] acc_q;
  logic        dzf_q, ovalid_q, oflag_q;
  logic signed [31:0] odrive_q;
  // divider
  logic [63:0] dnum_q;
  logic [31:0] drem_q;
  logic [5:0]  dcnt_q;
  logic        dneg_q;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [33:0] aerr;
  logic signed [33:0] olim_s, ilim_s;
  logic incr;
  logic signed [31:0] dsum;
  assign incr = mode_q[0];
  assign prod = ma * mb;
  assign aerr = err_q[31] ? -34'(err_q) : 34'(err_q);
  assign olim_s = $signed({3'b000, olim_q});
  assign ilim_s = $signed({3'b000, ilim_q});

  function automatic logic signed [31:0] fsh(input logic signed [65:0] v);
    return pid_pkg::sat32(67'(v >>> 16));
  endfunction
  function automatic logic sgs(input logic signed [31:0] a, input logic signed [31:0] b);
    return a != 0 && b != 0 && (a[31] == b[31]);
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_P: begin
        ma = 33'(gp_q);
        mb = incr ? 33'(pid_pkg::sat32(67'(err_q) - 67'(pe_q))) : 33'(err_q);
      end
      S_I: begin
        ma = 33'(gi_q);
        mb = mode_q[1] ? 33'(pid_pkg::sat32(67'((67'(err_q) + 67'(pe_q)) >>> 1)))
                       : 33'(err_q);
      end
      S_SEP: begin
        ma = 33'(i_q);
        mb = 33'(34'(bands_q[63:32]) + 34'(bands_q[31:0]) - aerr);
      end
      S_D: begin
        ma = 33'(gd_q);
        case ({mode_q[3], incr})
          2'b00: mb = 33'(pid_pkg::sat32(67'(err_q) - 67'(pe_q)));
          2'b01: mb = 33'(pid_pkg::sat32(67'(err_q) + 67'(pe2_q) - 67'(pe_q) * 2));
          2'b10: mb = 33'(pid_pkg::sat32(67'(pm_q) - 67'(meas_q)));
          default: mb = 33'(pid_pkg::sat32(67'(pm_q) * 2 - 67'(meas_q) - 67'(pm2_q)));
        endcase
      end
      S_DF1: begin ma = 33'(d_q);    mb = DA;  end
      S_DF2: begin ma = 33'(pd_q);   mb = DAN; end
      S_OF1: begin ma = 33'(drv_q);  mb = OA;  end
      S_OF2: begin ma = 33'(pdrv_q); mb = OAN; end
      default: ;
    endcase
  end

  assign dsum = pid_pkg::sat32(67'(p_q) + 67'(d_q) + 67'(i_q) + 67'(pdrv_q));
  assign in_ch.ready = (state_q == S_IDLE);
  assign out_ch.valid = ovalid_q;
  assign out_ch.data.drive = odrive_q;
  assign out_ch.data.in_dead_zone = oflag_q;

  logic [32:0] rtry;
  assign rtry = {drem_q, dnum_q[63]} - {1'b0, bands_q[63:32]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= '0; gp_q <= '0; gi_q <= '0; gd_q <= '0;
      olim_q <= '1; ilim_q <= '1; dz_q <= '0; bands_q <= '0;
      pe_q <= '0; pe2_q <= '0; pm_q <= '0; pm2_q <= '0;
      isum_q <= '0; pd_q <= '0; pdrv_q <= '0;
      meas_q <= '0; err_q <= '0; p_q <= '0; i_q <= '0; d_q <= '0; drv_q <= '0;
      acc_q <= '0; dzf_q <= 1'b0; oflag_q <= 1'b0; odrive_q <= '0;
      dnum_q <= '0; drem_q <= '0; dcnt_q <= '0; dneg_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pid_pkg::RegMode:   mode_q  <= cfg_data_i[7:0];
          pid_pkg::RegGainP:  gp_q    <= cfg_data_i[31:0];
          pid_pkg::RegGainI:  gi_q    <= cfg_data_i[31:0];
          pid_pkg::RegGainD:  gd_q    <= cfg_data_i[31:0];
          pid_pkg::RegOutLim: olim_q  <= cfg_data_i[30:0];
          pid_pkg::RegIntLim: ilim_q  <= cfg_data_i[30:0];
          pid_pkg::RegDead:   dz_q    <= cfg_data_i[30:0];
          pid_pkg::RegBands:  bands_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            meas_q <= in_ch.data.measured;
            err_q <= pid_pkg::sat32(67'(in_ch.data.target) - 67'(in_ch.data.measured));
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          dzf_q <= aerr <= 34'(dz_q);
          d_q <= pd_q;
          drv_q <= '0;
          if (aerr <= 34'(dz_q)) begin
            if (!mode_q[7]) isum_q <= '0;
            state_q <= S_OUT;
          end else state_q <= S_P;
        end
        S_P: begin p_q <= fsh(prod); state_q <= S_I; end
        S_I: begin
          i_q <= fsh(prod);
          state_q <= S_D;
          if (mode_q[2] && sgs(err_q, isum_q)) begin
            if (aerr > 34'(bands_q[63:32]) + 34'(bands_q[31:0])) i_q <= '0;
            else if (aerr > 34'(bands_q[31:0]) && bands_q[63:32] != 0) state_q <= S_SEP;
          end
        end
        S_SEP: begin
          dneg_q <= prod[65];
          dnum_q <= prod[65] ? 64'(-prod) : 64'(prod);
          drem_q <= '0;
          dcnt_q <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!rtry[32]) drem_q <= rtry[31:0];
          else drem_q <= {drem_q[30:0], dnum_q[63]};
          dnum_q <= {dnum_q[62:0], !rtry[32]};
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd63) begin
            i_q <= pid_pkg::sat32(dneg_q ? -67'({dnum_q[62:0], !rtry[32]})
                                         : 67'({dnum_q[62:0], !rtry[32]}));
            state_q <= S_D;
          end
        end
        S_D: begin
          d_q <= fsh(prod);
          state_q <= mode_q[4] ? S_DF1 : S_AW;
        end
        S_DF1: begin acc_q <= prod; state_q <= S_DF2; end
        S_DF2: begin d_q <= fsh(acc_q + prod); state_q <= S_AW; end
        S_AW: begin
          state_q <= S_SUM;
          if (mode_q[5]) begin
            if (incr) begin
              if ({1'b0, (dsum[31] ? -33'(dsum) : 33'(dsum))} > 34'(olim_q) &&
                  sgs(err_q, dsum)) i_q <= '0;
            end else begin
              logic signed [31:0] t, ti;
              t  = pid_pkg::sat32(67'(p_q) + 67'(isum_q) + 67'(d_q));
              ti = pid_pkg::sat32(67'(isum_q) + 67'(i_q));
              if ((t[31] ? -34'(t) : 34'(t)) > 34'(olim_q) && sgs(err_q, isum_q))
                i_q <= '0;
              if (34'(ti) > ilim_s) begin
                isum_q <= 32'(ilim_q); i_q <= '0;
              end else if (34'(ti) < -ilim_s) begin
                isum_q <= -32'(ilim_q); i_q <= '0;
              end
            end
          end
        end
        S_SUM: begin
          if (incr) drv_q <= dsum;
          else begin
            isum_q <= pid_pkg::sat32(67'(isum_q) + 67'(i_q));
            drv_q <= pid_pkg::sat32(67'(p_q) + 67'(d_q) +
                     67'(pid_pkg::sat32(67'(isum_q) + 67'(i_q))));
          end
          state_q <= mode_q[6] ? S_OF1 : S_OUT;
        end
        S_OF1: begin acc_q <= prod; state_q <= S_OF2; end
        S_OF2: begin drv_q <= fsh(acc_q + prod); state_q <= S_OUT; end
        S_OUT: begin
          if (!ovalid_q || out_ch.ready) begin
            if (!dzf_q) begin
              if (34'(drv_q) > olim_s) odrive_q <= 32'(olim_q);
              else if (34'(drv_q) < -olim_s) odrive_q <= -32'(olim_q);
              else odrive_q <= drv_q;
            end else odrive_q <= '0;
            pdrv_q <= dzf_q ? '0 : ((34'(drv_q) > olim_s) ? 32'(olim_q) :
                     (34'(drv_q) < -olim_s) ? -32'(olim_q) : drv_q);
            oflag_q <= dzf_q;
            pm2_q <= pm_q; pm_q <= meas_q;
            pe2_q <= pe_q; pe_q <= err_q;
            pd_q <= d_q;
            ovalid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
